[src/assert_macros.svh]
// Assertion macros used by the checker file of the token classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

[src/ctc_pkg.sv]
// Shared types, class codes and keyword table of the C token classifier.
package ctc_pkg;

   // Token class codes as they appear on the result channel.
   localparam logic [2:0] CLASS_KEYWORD    = 3'd0;
   localparam logic [2:0] CLASS_IDENTIFIER = 3'd1;
   localparam logic [2:0] CLASS_SPECIAL    = 3'd2;
   localparam logic [2:0] CLASS_ARITH      = 3'd3;
   localparam logic [2:0] CLASS_RELATIONAL = 3'd4;
   localparam logic [2:0] CLASS_COMMENT    = 3'd5;
   localparam logic [2:0] CLASS_FLOAT      = 3'd6;
   localparam logic [2:0] CLASS_INTEGER    = 3'd7;

   localparam int KW_COUNT = 32;
   localparam int KW_SLOTS = 8;

   // Characters used by the classifier.
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_UPPER_E    = 8'h45;
   localparam logic [7:0] CH_LOWER_E    = 8'h65;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_GREATER    = 8'h3E;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_DOLLAR     = 8'h24;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_CR         = 8'h0D;

   // One finished token as handed from the front end to the back end.
   typedef struct packed {
      logic       kw_hit;     // token equals a keyword
      logic [7:0] first_ch;
      logic [7:0] second_ch;
      logic [4:0] len_out;    // saturated length, low five bits
      logic       len_one;    // token is exactly one character
      logic       float_mark;
      logic       last;
   } tok_rec_type;

   // Keyword text, right-justified, first character in the highest used byte.
   function automatic logic [63:0] kw_word(input logic [4:0] idx);
      logic [63:0] w;
      case (idx)
         5'd0:  w = "auto";
         5'd1:  w = "double";
         5'd2:  w = "int";
         5'd3:  w = "struct";
         5'd4:  w = "break";
         5'd5:  w = "else";
         5'd6:  w = "long";
         5'd7:  w = "switch";
         5'd8:  w = "case";
         5'd9:  w = "enum";
         5'd10: w = "register";
         5'd11: w = "typedef";
         5'd12: w = "char";
         5'd13: w = "extern";
         5'd14: w = "return";
         5'd15: w = "union";
         5'd16: w = "continue";
         5'd17: w = "for";
         5'd18: w = "signed";
         5'd19: w = "void";
         5'd20: w = "do";
         5'd21: w = "if";
         5'd22: w = "static";
         5'd23: w = "while";
         5'd24: w = "default";
         5'd25: w = "goto";
         5'd26: w = "sizeof";
         5'd27: w = "volatile";
         5'd28: w = "const";
         5'd29: w = "float";
         5'd30: w = "short";
         5'd31: w = "unsigned";
         default: w = '0;
      endcase
      return w;
   endfunction

   // Number of characters in a keyword.
   function automatic logic [3:0] kw_len(input logic [4:0] idx);
      logic [63:0] w;
      logic [3:0]  n;
      w = kw_word(idx);
      n = 4'd0;
      for (int b = 0; b < KW_SLOTS; b++) begin
         if (w[b*8 +: 8] != 8'h00) begin
            n = 4'(b + 1);
         end
      end
      return n;
   endfunction

   // Character at a given position of a keyword; only valid below its length.
   function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [2:0] pos);
      logic [63:0] w;
      logic [6:0]  sh;
      w  = kw_word(idx);
      sh = {4'd8 - kw_len(idx), 3'b000};
      w  = w << sh;
      return w[{~pos, 3'b000} +: 8];
   endfunction

endpackage

[src/ctc_front.sv]
// Front end: takes characters, tracks the token in progress and emits finished tokens.
module ctc_front
   import ctc_pkg::*;
#(
   parameter int MAX_TOKEN = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_char,
   input  logic        in_last,
   input  logic        q_full,
   output logic        q_push,
   output tok_rec_type q_rec
);

   localparam int LEN_W = $clog2(MAX_TOKEN + 1);

   logic [KW_COUNT-1:0] match_ff, match_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [7:0]          first_ff, first_in;
   logic [7:0]          second_ff, second_in;
   logic                float_ff, float_in;

   logic                accept;
   logic                is_ws;
   logic                ending;
   logic [KW_COUNT-1:0] match_nx;
   logic [LEN_W-1:0]    len_nx;
   logic [7:0]          first_nx, second_nx;
   logic                float_nx;
   logic                kw_hit;

   // A character is taken whenever the queue has room for a possible token.
   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign is_ws    = (in_char == CH_SPACE) || ((in_char >= CH_TAB) && (in_char <= CH_CR));
   assign ending   = is_ws || in_last;

   // Token state after absorbing the current character, before any clear.
   always_comb begin
      match_nx  = match_ff;
      len_nx    = len_ff;
      first_nx  = first_ff;
      second_nx = second_ff;
      float_nx  = float_ff;
      if (!is_ws) begin
         if (len_ff == '0) begin
            first_nx = in_char;
         end
         if (len_ff == LEN_W'(1)) begin
            second_nx = in_char;
         end
         if ((in_char == CH_DOT) || (in_char == CH_UPPER_E) || (in_char == CH_LOWER_E)) begin
            float_nx = 1'b1;
         end
         // Every keyword compares its character at the current position in parallel.
         for (int i = 0; i < KW_COUNT; i++) begin
            if (!((len_ff < LEN_W'(kw_len(5'(i)))) &&
                  (kw_char(5'(i), len_ff[2:0]) == in_char))) begin
               match_nx[i] = 1'b0;
            end
         end
         if (len_ff < LEN_W'(MAX_TOKEN)) begin
            len_nx = len_ff + LEN_W'(1);
         end
      end
   end

   // A keyword is hit when a surviving prefix has exactly the keyword's length.
   always_comb begin
      kw_hit = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (match_nx[i] && (len_nx == LEN_W'(kw_len(5'(i))))) begin
            kw_hit = 1'b1;
         end
      end
   end

   // Finished token record; pushed only for a token that is not empty.
   always_comb begin
      q_rec.kw_hit     = kw_hit;
      q_rec.first_ch   = first_nx;
      q_rec.second_ch  = second_nx;
      q_rec.len_out    = 5'(len_nx);
      q_rec.len_one    = (len_nx == LEN_W'(1));
      q_rec.float_mark = float_nx;
      q_rec.last       = in_last;
   end
   assign q_push = accept && ending && (len_nx != '0);

   // Next register values: absorb, or clear when the token ends.
   always_comb begin
      match_in  = match_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      second_in = second_ff;
      float_in  = float_ff;
      if (accept) begin
         if (ending) begin
            match_in  = '1;
            len_in    = '0;
            first_in  = '0;
            second_in = '0;
            float_in  = 1'b0;
         end else begin
            match_in  = match_nx;
            len_in    = len_nx;
            first_in  = first_nx;
            second_in = second_nx;
            float_in  = float_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff  <= '1;
         len_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         float_ff  <= 1'b0;
      end else begin
         match_ff  <= match_in;
         len_ff    <= len_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         float_ff  <= float_in;
      end
   end

endmodule

[src/ctc_queue.sv]
// Two-entry queue of finished tokens between the front end and the back end.
module ctc_queue
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  tok_rec_type push_rec,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output tok_rec_type head_rec
);

   tok_rec_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_rec  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

[src/ctc_back.sv]
// Back end: assigns the class of a finished token and holds it in the output register.
module ctc_back
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  tok_rec_type q_rec,
   output logic        q_pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [2:0]  out_class,
   output logic [4:0]  out_len,
   output logic        out_last
);

   logic       valid_ff, valid_in;
   logic [2:0] class_ff, class_in;
   logic [4:0] len_ff, len_in;
   logic       last_ff, last_in;
   logic       load;
   logic [2:0] tok_class;
   logic [7:0] a, b;
   logic       is_letter, is_special, is_arith, is_rel;

   assign a = q_rec.first_ch;
   assign b = q_rec.second_ch;

   // Character groups of the first two characters.
   always_comb begin
      is_letter  = ((a >= 8'h41) && (a <= 8'h5A)) || ((a >= 8'h61) && (a <= 8'h7A)) ||
                   (a == CH_UNDERSCORE);
      is_special = (a == CH_DOLLAR) || (a == 8'h23) || (a == 8'h26) || (a == 8'h5E) ||
                   (a == 8'h7B) || (a == 8'h7D) || (a == 8'h5B) || (a == 8'h5D) ||
                   (a == 8'h3F) || (a == 8'h3A) || (a == 8'h28) || (a == 8'h29) ||
                   (a == 8'h3B);
      is_arith   = (a == 8'h2B) || (a == 8'h2D) || (a == 8'h2A) || (a == CH_SLASH) ||
                   (a == 8'h25);
      if (q_rec.len_one) begin
         is_rel = (a == CH_GREATER) || (a == CH_LESS);
      end else begin
         is_rel = (b == CH_EQUAL) && ((a == CH_GREATER) || (a == CH_LESS) ||
                                      (a == CH_EQUAL) || (a == CH_BANG));
      end
   end

   // Class tests in priority order.
   always_comb begin
      if (q_rec.kw_hit) begin
         tok_class = CLASS_KEYWORD;
      end else if (is_letter) begin
         tok_class = CLASS_IDENTIFIER;
      end else if (q_rec.len_one && is_special) begin
         tok_class = CLASS_SPECIAL;
      end else if (q_rec.len_one && is_arith) begin
         tok_class = CLASS_ARITH;
      end else if (is_rel) begin
         tok_class = CLASS_RELATIONAL;
      end else if ((a == CH_SLASH) && (b == CH_SLASH)) begin
         tok_class = CLASS_COMMENT;
      end else if (q_rec.float_mark) begin
         tok_class = CLASS_FLOAT;
      end else begin
         tok_class = CLASS_INTEGER;
      end
   end

   // The output register loads whenever it is empty or being drained.
   assign load  = q_not_empty && (!valid_ff || out_ready);
   assign q_pop = load;

   always_comb begin
      valid_in = valid_ff;
      class_in = class_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         class_in = tok_class;
         len_in   = q_rec.len_out;
         last_in  = q_rec.last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
      len_ff   <= len_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_class = class_ff;
   assign out_len   = len_ff;
   assign out_last  = last_ff;

endmodule

[src/c_token_classifier_top.sv]
// Top level of the C token classifier: front end, token queue and back end.
//
// Use: characters enter on the req_ stream, one byte per transfer, with
// req_tlast marking the last character of a line. Whitespace (tab to
// carriage return, and space) and the end of a line close the current
// token; every token that is not empty yields one transfer on the rsp_
// stream with its class and saturated length, and rsp_tlast set when the
// token closed at the end of a line.
// Throughput: one character per cycle while the token queue is not full.
// The keyword table is compared at the current position for all 32
// keywords in parallel, so no character waits on another.
// The queue takes a token at the transfer of the character that closes
// it; the classifier and output register take it from the queue once the
// output register is empty or being drained, and it then shows on rsp_.
// Reset clears the token in progress, empties the two-entry queue and drops
// rsp_tvalid. When the receiver stalls, the result stays in the output
// register, the queue fills with up to two more tokens, and req_tready
// falls only once the queue is full.
module c_token_classifier_top
   import ctc_pkg::*;
#(
   parameter int MAX_TOKEN = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] token_class, [7:3] token_length
   output logic       rsp_tlast    // last_token
);

   logic        q_full;
   logic        q_push;
   tok_rec_type q_in_rec;
   logic        q_pop;
   logic        q_not_empty;
   tok_rec_type q_head_rec;
   logic [2:0]  out_class;
   logic [4:0]  out_len;

   ctc_front #(
      .MAX_TOKEN (MAX_TOKEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_char  (req_tdata),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_rec    (q_in_rec)
   );

   ctc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (q_in_rec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_rec  (q_head_rec)
   );

   ctc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rec       (q_head_rec),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_class   (out_class),
      .out_len     (out_len),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {out_len, out_class};

endmodule

[src/ctc_checker.sv]
// Port-level checker for the C token classifier and its bind to the top level.
`include "assert_macros.svh"

module ctc_checker
   import ctc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic [2:0] rsp_class;
   logic [4:0] rsp_len;

   assign rsp_class = rsp_tdata[2:0];
   assign rsp_len   = rsp_tdata[7:3];

   // A stalled result keeps its valid.
   `ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A stalled result keeps its payload.
   `ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))

   // Every reported token has at least one character.
   `ASSERT_IMPLY(a_len_nonzero, clock, reset, rsp_tvalid, rsp_len != 5'd0)

   // A keyword is between two and eight characters long.
   `ASSERT_IMPLY(a_kw_len, clock, reset, rsp_tvalid && (rsp_class == CLASS_KEYWORD), (rsp_len >= 5'd2) && (rsp_len <= 5'd8))

   // The input is held off only while a result is waiting at the output.
   `ASSERT_IMPLY(a_stall_needs_result, clock, reset, !req_tready, rsp_tvalid)

endmodule

bind c_token_classifier_top ctc_checker u_ctc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
